>>> hdl/quaternion_yaw_smoother_macros.svh
// ----------------------------------------------------------------------------
// quaternion yaw smoother assertion macros
// shared concurrent assertion forms, reset-qualified on the async reset
// ----------------------------------------------------------------------------
`ifndef QUATERNION_YAW_SMOOTHER_MACROS_SVH
`define QUATERNION_YAW_SMOOTHER_MACROS_SVH

// same-cycle implication
`define QYS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qys assertion failed");

// next-cycle implication
`define QYS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qys assertion failed");

`endif

>>> hdl/qys_pkg.sv
// ----------------------------------------------------------------------------
// qys_pkg
// widths, constants, sequencer states and the angle step table
// ----------------------------------------------------------------------------
package qys_pkg;

	// field widths
	localparam int QUAT_W   = 16;
	localparam int WEIGHT_W = 17;
	localparam int FINE_W   = 25;
	localparam int DEG_W    = 9;
	localparam int FRAC_W   = 16;

	// angle iteration count and the table behind it
	localparam int ANGLE_ITERATIONS = 16;
	localparam int ANGLE_TABLE_SIZE = 24;
	localparam int ROT_STEPS = (ANGLE_ITERATIONS > ANGLE_TABLE_SIZE) ?
		ANGLE_TABLE_SIZE : ANGLE_ITERATIONS;
	localparam int CNT_W = $clog2(ANGLE_TABLE_SIZE);
	localparam int STEP_W = 22;

	// datapath widths
	localparam int CW      = 37;  // rotation vector, covers gain growth
	localparam int AW      = 26;  // signed angle accumulator, Q9.16 degrees
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int FACC_W  = 43;

	// angles in Q9.16 degrees
	localparam logic signed [AW-1:0] FULL_TURN = AW'(23592960);
	localparam logic signed [AW-1:0] HALF_TURN = AW'(11796480);
	localparam logic [FINE_W-1:0] FINE_MAX = FINE_W'(23592959);

	// filter constants
	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = WEIGHT_W'(65536);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(6554);
	localparam logic [FACC_W-1:0]   ROUND_HALF   = FACC_W'(32768);

	// product schedule
	localparam logic [CNT_W-1:0] PROD_XY   = CNT_W'(0);
	localparam logic [CNT_W-1:0] PROD_WZ   = CNT_W'(1);
	localparam logic [CNT_W-1:0] PROD_WW   = CNT_W'(2);
	localparam logic [CNT_W-1:0] PROD_XX   = CNT_W'(3);
	localparam logic [CNT_W-1:0] PROD_YY   = CNT_W'(4);
	localparam logic [CNT_W-1:0] PROD_ZZ   = CNT_W'(5);
	localparam logic [CNT_W-1:0] FILT_NEW  = CNT_W'(0);
	localparam logic [CNT_W-1:0] FILT_LAST = CNT_W'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROD,
		ST_PREP,
		ST_ROTATE,
		ST_WRAP,
		ST_FILT,
		ST_OUT
	} state_t;

	// round(atan(2^-i) * 65536) in degrees
	function automatic logic [STEP_W-1:0] step_angle(input logic [CNT_W-1:0] idx);
		logic [STEP_W-1:0] a;
		unique case (idx)
			5'd0:    a = 22'd2949120;
			5'd1:    a = 22'd1740967;
			5'd2:    a = 22'd919879;
			5'd3:    a = 22'd466945;
			5'd4:    a = 22'd234379;
			5'd5:    a = 22'd117304;
			5'd6:    a = 22'd58666;
			5'd7:    a = 22'd29335;
			5'd8:    a = 22'd14668;
			5'd9:    a = 22'd7334;
			5'd10:   a = 22'd3667;
			5'd11:   a = 22'd1833;
			5'd12:   a = 22'd917;
			5'd13:   a = 22'd458;
			5'd14:   a = 22'd229;
			5'd15:   a = 22'd115;
			5'd16:   a = 22'd57;
			5'd17:   a = 22'd29;
			5'd18:   a = 22'd14;
			5'd19:   a = 22'd7;
			5'd20:   a = 22'd4;
			5'd21:   a = 22'd2;
			5'd22:   a = 22'd1;
			default: a = 22'd0;
		endcase
		return a;
	endfunction

endpackage

>>> hdl/qys_if.sv
// ----------------------------------------------------------------------------
// qys channel interfaces
// valid/ready channels for the quaternion input and the yaw result
// ----------------------------------------------------------------------------
interface qys_quat_if;
	logic valid;
	logic ready;
	logic signed [qys_pkg::QUAT_W-1:0] quat_w;
	logic signed [qys_pkg::QUAT_W-1:0] quat_x;
	logic signed [qys_pkg::QUAT_W-1:0] quat_y;
	logic signed [qys_pkg::QUAT_W-1:0] quat_z;

	modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qys_yaw_if;
	logic valid;
	logic ready;
	logic [qys_pkg::DEG_W-1:0]  yaw_degrees;
	logic [qys_pkg::FINE_W-1:0] yaw_fine;

	modport source (output valid, yaw_degrees, yaw_fine, input ready);
	modport sink (input valid, yaw_degrees, yaw_fine, output ready);
endinterface

>>> hdl/quaternion_yaw_smoother.sv
// ----------------------------------------------------------------------------
// quaternion_yaw_smoother
// quaternion to yaw via a shared multiplier and an iterative angle unit,
// followed by an exponential low-pass filter
// ----------------------------------------------------------------------------
// One quaternion beat is taken while the block is idle; it then steps
// through the products, the angle unit, the wrap and the filter before the
// result beat is shown, and a zero vector skips the angle steps. The next
// quaternion can be taken in the same cycle that the result is shown. The
// time per item is set by the single 26x18 multiplier, which forms the six
// squares and cross products one a cycle and then the two filter terms, and
// by the shift/add angle unit, which does one step a cycle. The result sits
// in an output register, so the next quaternion may be taken while it waits;
// the block only holds in its last step if a new result is ready before the
// old one has been taken. Negative angles get 360 degrees added; the filter
// does not handle the 0/360 wrap. A smoothing weight above 1.0 is treated as
// 1.0.
// ----------------------------------------------------------------------------
module quaternion_yaw_smoother (
	input  logic                              clk,
	input  logic                              arst_n,
	qys_quat_if.sink                          quat,
	qys_yaw_if.source                         yaw,
	input  logic                              cfg_we,
	input  logic [qys_pkg::WEIGHT_W-1:0]      cfg_wdata
);

	qys_pkg::state_t state_q, state_d;

	logic [qys_pkg::CNT_W-1:0]          cnt_q;
	logic signed [qys_pkg::QUAT_W-1:0]  w_q, x_q, y_q, z_q;
	logic signed [qys_pkg::CW-1:0]      cx_q, cy_q;
	logic signed [qys_pkg::AW-1:0]      ang_q;
	logic [qys_pkg::FINE_W-1:0]         raw_q;
	logic [qys_pkg::FACC_W-1:0]         facc_q;
	logic [qys_pkg::FINE_W-1:0]         last_q;
	logic [qys_pkg::WEIGHT_W-1:0]       weight_q;
	logic                               out_valid_q;
	logic [qys_pkg::DEG_W-1:0]          out_deg_q;
	logic [qys_pkg::FINE_W-1:0]         out_fine_q;

	logic [qys_pkg::WEIGHT_W-1:0]       weight_sat;
	logic signed [qys_pkg::MUL_A_W-1:0] mul_a;
	logic signed [qys_pkg::MUL_B_W-1:0] mul_b;
	logic signed [qys_pkg::MUL_P_W-1:0] mul_p;
	logic signed [qys_pkg::CW-1:0]      prod_c;
	logic signed [qys_pkg::CW-1:0]      cy_dbl;
	logic signed [qys_pkg::CW-1:0]      dx, dy;
	logic signed [qys_pkg::AW-1:0]      step_s;
	logic signed [qys_pkg::AW-1:0]      ang_wrap;
	logic                               last_step;
	logic                               out_free;
	logic [qys_pkg::FACC_W-1:0]         filt_full;

	// weight saturates at one
	assign weight_sat = (weight_q > qys_pkg::WEIGHT_ONE) ? qys_pkg::WEIGHT_ONE : weight_q;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == qys_pkg::ST_FILT) begin
			if (cnt_q == qys_pkg::FILT_NEW) begin
				mul_a = $signed({1'b0, raw_q});
				mul_b = $signed({1'b0, weight_sat});
			end else begin
				mul_a = $signed({1'b0, last_q});
				mul_b = $signed({1'b0, qys_pkg::WEIGHT_ONE - weight_sat});
			end
		end else begin
			unique case (cnt_q)
				qys_pkg::PROD_XY: begin
					mul_a = qys_pkg::MUL_A_W'(x_q);
					mul_b = qys_pkg::MUL_B_W'(y_q);
				end
				qys_pkg::PROD_WZ: begin
					mul_a = qys_pkg::MUL_A_W'(w_q);
					mul_b = qys_pkg::MUL_B_W'(z_q);
				end
				qys_pkg::PROD_WW: begin
					mul_a = qys_pkg::MUL_A_W'(w_q);
					mul_b = qys_pkg::MUL_B_W'(w_q);
				end
				qys_pkg::PROD_XX: begin
					mul_a = qys_pkg::MUL_A_W'(x_q);
					mul_b = qys_pkg::MUL_B_W'(x_q);
				end
				qys_pkg::PROD_YY: begin
					mul_a = qys_pkg::MUL_A_W'(y_q);
					mul_b = qys_pkg::MUL_B_W'(y_q);
				end
				qys_pkg::PROD_ZZ: begin
					mul_a = qys_pkg::MUL_A_W'(z_q);
					mul_b = qys_pkg::MUL_B_W'(z_q);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign mul_p  = mul_a * mul_b;
	assign prod_c = mul_p[qys_pkg::CW-1:0];

	// angle unit: floor shifts and table step
	assign cy_dbl = cy_q <<< 1;
	assign dx     = cy_q >>> cnt_q;
	assign dy     = cx_q >>> cnt_q;
	assign step_s = $signed({{(qys_pkg::AW - qys_pkg::STEP_W){1'b0}},
		qys_pkg::step_angle(cnt_q)});
	assign ang_wrap  = (ang_q < 0) ? ang_q + qys_pkg::FULL_TURN : ang_q;
	assign last_step = (cnt_q == qys_pkg::CNT_W'(qys_pkg::ROT_STEPS - 1));
	assign out_free  = !out_valid_q || yaw.ready;
	assign filt_full = facc_q >> qys_pkg::FRAC_W;

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qys_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake
	always_comb begin
		state_d    = state_q;
		quat.ready = 1'b0;
		unique case (state_q)
			qys_pkg::ST_IDLE: begin
				quat.ready = 1'b1;
				if (quat.valid) state_d = qys_pkg::ST_PROD;
			end
			qys_pkg::ST_PROD: begin
				if (cnt_q == qys_pkg::PROD_ZZ) state_d = qys_pkg::ST_PREP;
			end
			qys_pkg::ST_PREP: begin
				if (cx_q == '0 && cy_dbl == '0) state_d = qys_pkg::ST_FILT;
				else state_d = qys_pkg::ST_ROTATE;
			end
			qys_pkg::ST_ROTATE: begin
				if (last_step) state_d = qys_pkg::ST_WRAP;
			end
			qys_pkg::ST_WRAP: begin
				state_d = qys_pkg::ST_FILT;
			end
			qys_pkg::ST_FILT: begin
				if (cnt_q == qys_pkg::FILT_LAST) state_d = qys_pkg::ST_OUT;
			end
			qys_pkg::ST_OUT: begin
				if (out_free) state_d = qys_pkg::ST_IDLE;
			end
			default: state_d = qys_pkg::ST_IDLE;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q != state_d) begin
			cnt_q <= '0;
		end else if (state_q != qys_pkg::ST_IDLE && state_q != qys_pkg::ST_OUT) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// configuration register and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= qys_pkg::WEIGHT_RESET;
			last_q   <= '0;
		end else begin
			if (cfg_we) weight_q <= cfg_wdata;
			if (state_q == qys_pkg::ST_OUT && out_free)
				last_q <= filt_full[qys_pkg::FINE_W-1:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			qys_pkg::ST_IDLE: begin
				w_q <= quat.quat_w;
				x_q <= quat.quat_x;
				y_q <= quat.quat_y;
				z_q <= quat.quat_z;
			end
			qys_pkg::ST_PROD: begin
				unique case (cnt_q)
					qys_pkg::PROD_XY: cy_q <= prod_c;
					qys_pkg::PROD_WZ: cy_q <= cy_q + prod_c;
					qys_pkg::PROD_WW: cx_q <= prod_c;
					qys_pkg::PROD_XX: cx_q <= cx_q + prod_c;
					default:          cx_q <= cx_q - prod_c;
				endcase
			end
			qys_pkg::ST_PREP: begin
				raw_q <= '0;
				if (cx_q < 0) begin
					cx_q  <= -cx_q;
					cy_q  <= -cy_dbl;
					ang_q <= (cy_dbl >= 0) ? qys_pkg::HALF_TURN : -qys_pkg::HALF_TURN;
				end else begin
					cy_q  <= cy_dbl;
					ang_q <= '0;
				end
			end
			qys_pkg::ST_ROTATE: begin
				if (cy_q > 0) begin
					cx_q  <= cx_q + dx;
					cy_q  <= cy_q - dy;
					ang_q <= ang_q + step_s;
				end else begin
					cx_q  <= cx_q - dx;
					cy_q  <= cy_q + dy;
					ang_q <= ang_q - step_s;
				end
			end
			qys_pkg::ST_WRAP: begin
				if (ang_wrap < 0) raw_q <= '0;
				else if (ang_wrap >= qys_pkg::FULL_TURN) raw_q <= qys_pkg::FINE_MAX;
				else raw_q <= ang_wrap[qys_pkg::FINE_W-1:0];
			end
			qys_pkg::ST_FILT: begin
				if (cnt_q == qys_pkg::FILT_NEW)
					facc_q <= mul_p[qys_pkg::FACC_W-1:0] + qys_pkg::ROUND_HALF;
				else
					facc_q <= facc_q + mul_p[qys_pkg::FACC_W-1:0];
			end
			default: begin
				facc_q <= facc_q;
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == qys_pkg::ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (yaw.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == qys_pkg::ST_OUT && out_free) begin
			out_fine_q <= filt_full[qys_pkg::FINE_W-1:0];
			out_deg_q  <= filt_full[qys_pkg::FRAC_W +: qys_pkg::DEG_W];
		end
	end

	assign yaw.valid       = out_valid_q;
	assign yaw.yaw_degrees = out_deg_q;
	assign yaw.yaw_fine    = out_fine_q;

endmodule

>>> hdl/qys_checker.sv
// ----------------------------------------------------------------------------
// qys_checker
// port-level checks on the quaternion yaw smoother, bound to the top level
// ----------------------------------------------------------------------------
`include "quaternion_yaw_smoother_macros.svh"

module qys_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [qys_pkg::DEG_W-1:0]     yaw_degrees,
	input logic [qys_pkg::FINE_W-1:0]    yaw_fine
);

	// one beat at a time: busy right after taking a quaternion
	`QYS_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a stalled result holds its value
	`QYS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(yaw_fine))

	// whole degrees track the fine value
	`QYS_ASSERT_SAME(a_deg_match, clk, arst_n, out_valid,
		yaw_degrees == yaw_fine[qys_pkg::FRAC_W +: qys_pkg::DEG_W])

	// filtered yaw stays below a full turn
	`QYS_ASSERT_SAME(a_fine_range, clk, arst_n, out_valid, yaw_fine <= qys_pkg::FINE_MAX)

endmodule

bind quaternion_yaw_smoother qys_checker u_qys_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (quat.valid),
	.in_ready    (quat.ready),
	.out_valid   (yaw.valid),
	.out_ready   (yaw.ready),
	.yaw_degrees (yaw.yaw_degrees),
	.yaw_fine    (yaw.yaw_fine)
);

>>> dv/tb_quaternion_yaw_smoother.sv
// ----------------------------------------------------------------------------
// tb_quaternion_yaw_smoother
// self-checking bench for the quaternion yaw smoother: quaternion beats go in
// from a queue, a bit-exact yaw/filter predictor builds the expected beats and
// the monitor checks every yaw beat in order, across a sweep of weights
// ----------------------------------------------------------------------------
module tb_quaternion_yaw_smoother;

	localparam int ITEMS_PER_PHASE = 136;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 40;
	localparam int STALL_LIMIT     = 4000;
	localparam int IDLE_PERCENT    = 13;

	localparam longint FULL_TURN_Q16 = 23592960;
	localparam longint HALF_TURN_Q16 = 11796480;
	localparam longint ALPHA_ONE     = 65536;

	typedef struct packed {
		logic signed [qys_pkg::QUAT_W-1:0] w;
		logic signed [qys_pkg::QUAT_W-1:0] x;
		logic signed [qys_pkg::QUAT_W-1:0] y;
		logic signed [qys_pkg::QUAT_W-1:0] z;
	} quat_t;

	typedef struct packed {
		logic [qys_pkg::DEG_W-1:0]  degrees;
		logic [qys_pkg::FINE_W-1:0] fine;
	} yaw_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [qys_pkg::WEIGHT_W-1:0] cfg_wdata;

	qys_quat_if quat_bus ();
	qys_yaw_if  yaw_bus ();

	quaternion_yaw_smoother dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.quat      (quat_bus),
		.yaw       (yaw_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// predictor state: filter memory and the weight as last written
	longint model_last_yaw = 0;
	longint smoothing_alpha = 6554;

	// round(atan(2^-i) * 65536), degrees
	longint atan_step_q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	quat_t pending_quats [$];
	yaw_t  expected_yaws [$];
	yaw_t  oldest_yaw;

	bit steady_flow = 1'b0;
	int holds_requested = 0;
	int holds_served = 0;
	int hold_left = 0;
	int mismatches = 0;
	int quats_accepted = 0;
	int yaws_checked = 0;
	int stall_cycles = 0;

	task automatic log_mismatch(input string msg);
		mismatches++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	// yaw of one quaternion by shift/add vectoring, then the low-pass filter
	function automatic yaw_t predict_yaw(input quat_t q);
		longint w, x, y, z, vx, vy, ang, dx, dy, alpha;
		int i;
		yaw_t r;
		w = $signed(q.w);
		x = $signed(q.x);
		y = $signed(q.y);
		z = $signed(q.z);
		vy = 2 * (x * y + w * z);
		vx = w * w + x * x - y * y - z * z;
		ang = 0;
		if (vx != 0 || vy != 0) begin
			// left half plane: flip the vector and start from +/-180
			if (vx < 0) begin
				ang = (vy >= 0) ? HALF_TURN_Q16 : -HALF_TURN_Q16;
				vx = -vx;
				vy = -vy;
			end
			for (i = 0; i < qys_pkg::ROT_STEPS; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy > 0) begin
					vx += dx;
					vy -= dy;
					ang += atan_step_q16[i];
				end else begin
					vx -= dx;
					vy += dy;
					ang -= atan_step_q16[i];
				end
			end
			if (ang < 0)
				ang += FULL_TURN_Q16;
			if (ang < 0)
				ang = 0;
			if (ang >= FULL_TURN_Q16)
				ang = FULL_TURN_Q16 - 1;
		end
		alpha = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;
		model_last_yaw = ((alpha * ang + (ALPHA_ONE - alpha) * model_last_yaw + 32768) >>> 16)
			& 64'h1FF_FFFF;
		r.fine = model_last_yaw[qys_pkg::FINE_W-1:0];
		r.degrees = model_last_yaw[qys_pkg::FINE_W-1:qys_pkg::FRAC_W];
		return r;
	endfunction

	task automatic push_quat(input int w, input int x, input int y, input int z);
		quat_t q;
		q.w = qys_pkg::QUAT_W'(w);
		q.x = qys_pkg::QUAT_W'(x);
		q.y = qys_pkg::QUAT_W'(y);
		q.z = qys_pkg::QUAT_W'(z);
		pending_quats = {pending_quats, q};
	endtask

	task automatic wait_drained();
		while (pending_quats.size() != 0 || expected_yaws.size() != 0)
			@(posedge clk);
	endtask

	// quaternion driver: keeps valid up until the beat is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_bus.valid <= 1'b0;
			quat_bus.quat_w <= '0;
			quat_bus.quat_x <= '0;
			quat_bus.quat_y <= '0;
			quat_bus.quat_z <= '0;
		end else begin
			if (quat_bus.valid && quat_bus.ready) begin
				expected_yaws = {expected_yaws, predict_yaw(pending_quats.pop_front())};
				quats_accepted++;
			end
			if (!quat_bus.valid || quat_bus.ready) begin
				if (pending_quats.size() != 0 &&
						(steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
					quat_bus.valid <= 1'b1;
					quat_bus.quat_w <= pending_quats[0].w;
					quat_bus.quat_x <= pending_quats[0].x;
					quat_bus.quat_y <= pending_quats[0].y;
					quat_bus.quat_z <= pending_quats[0].z;
				end else begin
					quat_bus.valid <= 1'b0;
				end
			end
		end
	end

	// yaw monitor: checks each beat, random stalls and long hold-offs
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_bus.ready <= 1'b0;
			hold_left = 0;
		end else begin
			if (yaw_bus.valid && yaw_bus.ready) begin
				yaws_checked++;
				if (expected_yaws.size() == 0) begin
					log_mismatch($sformatf("unexpected yaw beat degrees=%0d fine=%0d",
						yaw_bus.yaw_degrees, yaw_bus.yaw_fine));
				end else begin
					oldest_yaw = expected_yaws.pop_front();
					if (yaw_bus.yaw_degrees !== oldest_yaw.degrees)
						log_mismatch($sformatf("beat %0d yaw_degrees got %0d want %0d",
							yaws_checked, yaw_bus.yaw_degrees, oldest_yaw.degrees));
					if (yaw_bus.yaw_fine !== oldest_yaw.fine)
						log_mismatch($sformatf("beat %0d yaw_fine got %0d want %0d",
							yaws_checked, yaw_bus.yaw_fine, oldest_yaw.fine));
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				yaw_bus.ready <= 1'b0;
			end else if (holds_served != holds_requested) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
				yaw_bus.ready <= 1'b0;
			end else begin
				yaw_bus.ready <= steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT;
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if (!arst_n || (quat_bus.valid && quat_bus.ready) ||
				(yaw_bus.valid && yaw_bus.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout: no beat for %0d cycles, %0d yaw beats outstanding",
					STALL_LIMIT, expected_yaws.size());
				$display("quaternion_yaw_smoother regression: fail");
				$finish;
			end
		end
	end

	// stimulus: directed corners, then one random phase per weight setting
	initial begin : stimulus
		int unsigned weight_plan [9];
		int comp [4];
		int sel;
		int p;
		int k;
		int directed_count;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed corners at the reset weight
		push_quat(16384, 0, 0, 0);          // identity, yaw 0
		push_quat(0, 0, 0, 0);              // zero vector
		push_quat(11585, 0, 0, 11585);      // +90
		push_quat(11585, 0, 0, -11585);     // -90, wraps to 270
		push_quat(0, 0, 0, 16384);          // on the negative axis, +180 start
		push_quat(0, 16384, 0, 0);          // num zero, den positive
		push_quat(0, 0, 16384, 0);          // num zero, den negative
		push_quat(-16384, -16384, -16384, -16384);
		push_quat(16384, 16384, 16384, 16384);
		push_quat(-32768, -32768, -32768, -32768);  // components beyond +/-16384
		push_quat(32767, 32767, 32767, 32767);
		push_quat(-32768, 32767, -32768, 32767);
		push_quat(32767, -32768, 32767, -32768);
		push_quat(1000, 0, 16384, -1000);   // left half plane, num negative
		push_quat(1000, 0, 16384, 1000);    // left half plane, num positive
		push_quat(1, 0, 0, 1);              // tiny vector on the +y axis
		push_quat(0, 1, -1, 0);             // tiny vector on the -y axis
		push_quat(-1, 0, 0, 0);
		push_quat(0, 0, 0, -1);
		push_quat(-16384, 0, 0, 16384);     // straight down, 270
		push_quat(16384, 0, 0, -1);         // just under 360
		push_quat(16384, 0, 0, 1);          // just over 0
		directed_count = pending_quats.size();

		// weight sweep: one, zero, saturated, tiny, half, random, reset value
		weight_plan = '{65536, 0, 131071, 65537, 1, 32768,
			$urandom_range(2, 65535), $urandom_range(65538, 131070), 6554};
		for (p = 0; p < 9; p++) begin
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= qys_pkg::WEIGHT_W'(weight_plan[p]);
			smoothing_alpha = weight_plan[p];
			@(posedge clk);
			cfg_we <= 1'b0;
			steady_flow = (p == 0);
			repeat (ITEMS_PER_PHASE) begin
				sel = $urandom_range(0, 99);
				for (k = 0; k < 4; k++) begin
					if (sel < 60)
						comp[k] = int'($urandom_range(0, 32768)) - 16384;
					else if (sel < 70)
						comp[k] = (k == 1 || k == 2) ? 0 :
							int'($urandom_range(0, 32768)) - 16384;
					else if (sel < 85)
						comp[k] = int'($urandom_range(0, 65535)) - 32768;
					else
						comp[k] = int'($urandom_range(0, 8)) - 4;
				end
				push_quat(comp[0], comp[1], comp[2], comp[3]);
			end
			// receiver backs off while the sender keeps offering
			if (p == 2 || p == 5)
				holds_requested++;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d quaternions (%0d directed corners) over 9 weight settings,",
			quats_accepted, directed_count);
		$display("weights 0, 1.0 and saturated included, %0d yaw beats checked, %0d hold-offs",
			yaws_checked, holds_served);
		if (mismatches == 0 && expected_yaws.size() == 0)
			$display("quaternion_yaw_smoother regression: pass");
		else
			$display("quaternion_yaw_smoother regression: fail");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hdl
hdl/qys_pkg.sv
hdl/qys_if.sv
hdl/quaternion_yaw_smoother.sv
hdl/qys_checker.sv
dv/tb_quaternion_yaw_smoother.sv
